// ===== hdl/wlrs_pkg.sv =====
// Package for the wear-levelled record store: sizes, command codes and
// sequencer states.
// No dependencies.
package wlrs_pkg;

   localparam int RECORD_BYTES = 15;
   localparam int STORE_SIZE   = 256;
   localparam int SLOT_BYTES   = RECORD_BYTES + 1;

   localparam int ADDR_W = $clog2(STORE_SIZE);
   localparam int OFF_W  = $clog2(STORE_SIZE + 2 * SLOT_BYTES);
   localparam int BUF_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   localparam logic [OFF_W-1:0] SLOT_OFF   = OFF_W'(SLOT_BYTES);
   localparam logic [OFF_W-1:0] RECORD_OFF = OFF_W'(RECORD_BYTES);
   localparam logic [OFF_W-1:0] STORE_OFF  = OFF_W'(STORE_SIZE);
   localparam logic [OFF_W-1:0] LAST_ADDR  = OFF_W'(STORE_SIZE - 1);

   localparam logic [7:0] ERASED_BYTE  = 8'hFF;
   localparam logic [7:0] MARKER_RESET = 8'd165;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_LOAD  = 2'd2,
      CMD_SAVE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_ADDR,
      ST_LD_CHECK,
      ST_LD_COPY,
      ST_SV_ERASE,
      ST_SV_RECORD
   } state_type;

endpackage

// ===== hdl/wear_levelled_record_store.sv =====
// Top level of the wear-levelled record store: record buffer, store memory
// and the command sequencer.
// Depends on wlrs_pkg.

// Commands are taken when start is high and busy low; each command gives
// one transfer on the rsp_ ports, strobed by rsp_valid for one cycle, which
// the receiver cannot stall. Buffer write and read give their result in the
// cycle after acceptance and busy stays low. Load reads the marker byte of
// each slot in turn and, on a match, copies the record bytes of that slot
// into the buffer; save makes SLOT_BYTES erase writes plus SLOT_BYTES record
// and marker writes. The store memory has a single port, which takes one
// byte per cycle. After reset the store is swept to 0xFF, all STORE_SIZE
// (256) bytes, with busy high; csr_ writes are taken during that sweep.
module wear_levelled_record_store
   import wlrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_command,
   input  logic [3:0] req_byte_index,
   input  logic [7:0] req_write_byte,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_found,
   output logic [7:0] rsp_slot_offset,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   state_type         state_ff, state_in;
   logic [OFF_W-1:0]  cnt_ff, cnt_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [OFF_W-1:0]  cur_ff, cur_in;
   logic [7:0]        marker_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_read_ff, rsp_read_in;
   logic              rsp_found_ff, rsp_found_in;

   logic [7:0]        mem_ff [STORE_SIZE];
   logic [7:0]        mem_rd_ff;
   logic              mem_we;
   logic [OFF_W-1:0]  mem_addr;
   logic [7:0]        mem_wdata;

   logic [7:0]        buf_ff [RECORD_BYTES];
   logic              buf_we;
   logic [BUF_W-1:0]  buf_waddr;
   logic [7:0]        buf_wdata;
   logic [BUF_W-1:0]  buf_raddr;
   logic [7:0]        buf_rdata;
   logic              idx_ok;
   logic [OFF_W-1:0]  next_slot;

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_byte   = rsp_read_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot_offset = 8'(cur_ff);

   assign idx_ok    = (32'(req_byte_index) < RECORD_BYTES);
   assign buf_raddr = (state_ff == ST_SV_RECORD) ? BUF_W'(cnt_ff) : BUF_W'(req_byte_index);
   assign buf_rdata = buf_ff[buf_raddr];
   assign next_slot = ((cur_ff + SLOT_OFF + SLOT_OFF) > STORE_OFF) ? '0 : cur_ff + SLOT_OFF;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      cur_in       = cur_ff;
      mem_we       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = ERASED_BYTE;
      buf_we       = 1'b0;
      buf_waddr    = '0;
      buf_wdata    = '0;
      rsp_valid_in = 1'b0;
      rsp_read_in  = '0;
      rsp_found_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = cnt_ff;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (cmd_type'(req_command))
                  CMD_WRITE: begin
                     buf_we       = idx_ok;
                     buf_waddr    = BUF_W'(req_byte_index);
                     buf_wdata    = req_write_byte;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_READ: begin
                     rsp_read_in  = idx_ok ? buf_rdata : 8'd0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_LOAD: begin
                     off_in = '0;
                     if (SLOT_OFF <= STORE_OFF) begin
                        state_in = ST_LD_ADDR;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_SAVE: begin
                     cnt_in   = '0;
                     state_in = ST_SV_ERASE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LD_ADDR: begin
            mem_addr = off_ff;
            state_in = ST_LD_CHECK;
         end
         ST_LD_CHECK: begin
            if (mem_rd_ff == marker_ff) begin
               cur_in   = off_ff;
               cnt_in   = '0;
               state_in = ST_LD_COPY;
            end else if ((off_ff + SLOT_OFF + SLOT_OFF) <= STORE_OFF) begin
               off_in   = off_ff + SLOT_OFF;
               state_in = ST_LD_ADDR;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LD_COPY: begin
            mem_addr = off_ff + 1'b1 + cnt_ff;
            if (cnt_ff != '0) begin
               buf_we    = 1'b1;
               buf_waddr = BUF_W'(cnt_ff - 1'b1);
               buf_wdata = mem_rd_ff;
            end
            if (cnt_ff == RECORD_OFF) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SV_ERASE: begin
            mem_addr = cur_ff + cnt_ff;
            mem_we   = (mem_addr < STORE_OFF);
            if (cnt_ff == SLOT_OFF - 1'b1) begin
               cur_in   = next_slot;
               cnt_in   = '0;
               state_in = ST_SV_RECORD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SV_RECORD: begin
            if (cnt_ff < RECORD_OFF) begin
               mem_addr  = cur_ff + 1'b1 + cnt_ff;
               mem_wdata = buf_rdata;
               cnt_in    = cnt_ff + 1'b1;
            end else begin
               mem_addr     = cur_ff;
               mem_wdata    = marker_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
            mem_we = (mem_addr < STORE_OFF);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         off_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= '0;
         rsp_found_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         off_ff       <= off_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_read_ff  <= rsp_read_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
      end else if (csr_write_en) begin
         marker_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RECORD_BYTES; i++) begin
            buf_ff[i] <= '0;
         end
      end else if (buf_we) begin
         buf_ff[buf_waddr] <= buf_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr[ADDR_W-1:0]] <= mem_wdata;
      end
      mem_rd_ff <= mem_ff[mem_addr[ADDR_W-1:0]];
   end

`ifndef SYNTHESIS
   a_found_strobed : assert property (@(posedge clock) disable iff (reset)
      rsp_found |-> rsp_valid)
      else $error("found raised without a transfer");

   a_slot_aligned : assert property (@(posedge clock) disable iff (reset)
      (32'(cur_ff) % SLOT_BYTES == 0) && ((cur_ff + SLOT_OFF <= STORE_OFF) || (cur_ff == '0)))
      else $error("current slot off a slot boundary");

   a_quick_result : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_WRITE || req_command == CMD_READ) |=> rsp_valid)
      else $error("buffer command gave no transfer");

   a_idle_no_write : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> busy)
      else $error("store written while idle");

   a_clear_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !rsp_valid)
      else $error("transfer during clearing sweep");
`endif

endmodule
